[src/mba_pkg.sv]
package mba_pkg;

    localparam int NUM_CH          = 9;
    localparam int FIRST_AUX       = 7;
    localparam int CH_W            = 4;
    localparam int SAMPLE_W        = 16;
    localparam int SUM_W           = 32;
    localparam int THRESH_W        = 12;
    localparam int AUX_CHANNELS_DEF = 2;
    localparam int COUNT_MAX_DEF   = 4095;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd214;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ADD,
        S_DIV,
        S_PUSH
    } t_state;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;

endpackage

[src/mba_ifs.sv]
interface mba_scan_if import mba_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    restart;
    t_sample x_rate;
    t_sample y_rate;
    t_sample z_rate;
    t_sample ref_volt;
    t_sample x_accel;
    t_sample y_accel;
    t_sample z_accel;
    t_sample aux_zero;
    t_sample aux_one;

    modport source (
        output valid, restart, x_rate, y_rate, z_rate, ref_volt,
               x_accel, y_accel, z_accel, aux_zero, aux_one,
        input  ready
    );
    modport sink (
        input  valid, restart, x_rate, y_rate, z_rate, ref_volt,
               x_accel, y_accel, z_accel, aux_zero, aux_one,
        output ready
    );
endinterface

interface mba_avg_if import mba_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample x_rate_avg;
    t_sample y_rate_avg;
    t_sample z_rate_avg;
    t_sample ref_volt_avg;
    t_sample x_accel_avg;
    t_sample y_accel_avg;
    t_sample z_accel_avg;
    t_sample aux_zero_avg;
    t_sample aux_one_avg;
    logic    fresh;
    logic    count_full;

    modport source (
        output valid, x_rate_avg, y_rate_avg, z_rate_avg, ref_volt_avg,
               x_accel_avg, y_accel_avg, z_accel_avg, aux_zero_avg,
               aux_one_avg, fresh, count_full,
        input  ready
    );
    modport sink (
        input  valid, x_rate_avg, y_rate_avg, z_rate_avg, ref_volt_avg,
               x_accel_avg, y_accel_avg, z_accel_avg, aux_zero_avg,
               aux_one_avg, fresh, count_full,
        output ready
    );
endinterface

[src/mba_sum_ram.sv]
module mba_sum_ram import mba_pkg::*; (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [CH_W-1:0] i_waddr,
    input  t_sum            i_wdata,
    input  logic            i_re,
    input  logic [CH_W-1:0] i_raddr,
    output t_sum            o_rdata
);

    t_sum r_mem [NUM_CH];
    t_sum r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/mba_div.sv]
module mba_div import mba_pkg::*; #(
    parameter int CW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_sum          i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output t_sample       o_quotient
);

    localparam int ITW = $clog2(SUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [ITW-1:0]   r_cnt;
    logic [SUM_W-1:0] r_mag;
    logic             r_neg;
    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    r_div;

    logic [CW:0]      w_trial;
    logic             w_ge;
    logic [SUM_W-1:0] w_abs;

    assign w_abs   = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
    assign w_trial = {r_rem, r_mag[SUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ITW'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= w_abs;
            r_neg <= i_dividend[SUM_W-1];
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? CW'(w_trial - {1'b0, r_div}) : CW'(w_trial);
            r_mag <= {r_mag[SUM_W-2:0], w_ge};
        end
    end

    // truncated toward zero, clamped to the sample range
    always_comb begin
        if (r_neg) begin
            if (r_mag > SUM_W'(32768)) begin
                o_quotient = 16'sh8000;
            end else begin
                o_quotient = SAMPLE_W'(-r_mag);
            end
        end else begin
            if (r_mag > SUM_W'(32767)) begin
                o_quotient = 16'sh7FFF;
            end else begin
                o_quotient = SAMPLE_W'(r_mag);
            end
        end
    end

    assign o_done = r_done;

endmodule

[src/multichannel_boxcar_averager_top.sv]
// Channel    Dir  Carries
// i_scan     in   restart flag and nine channel samples
// o_avg      out  nine held averages, fresh, count_full
// i_cfg_*    in   scan count threshold for recomputing averages
//
// A scan visits every channel in turn (sum RAM read, then add and, for active
// channels, write back), plus a divide per active channel when averages are
// recomputed (serial restoring divider, one quotient bit a cycle).
// Reset is synchronous; sums read as zero until written after reset or restart.
// A finished result waits in the output register; the next scan is taken meanwhile.
// A second result waits until that register is taken, holding off the input.
module multichannel_boxcar_averager_top import mba_pkg::*; #(
    parameter int AUX_CHANNELS = AUX_CHANNELS_DEF,
    parameter int COUNT_MAX    = COUNT_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THRESH_W-1:0] i_cfg_wdata,
    mba_scan_if.sink            i_scan,
    mba_avg_if.source           o_avg
);

    localparam int CW      = $clog2(COUNT_MAX + 1);
    localparam int CMPW    = (CW > THRESH_W) ? CW : THRESH_W;
    localparam int NUM_ACT = FIRST_AUX + AUX_CHANNELS;
    localparam logic [CW-1:0]   CNT_MAX = CW'(COUNT_MAX);
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);
    localparam logic [CH_W-1:0] CH_ACT  = CH_W'(NUM_ACT);

    t_state              r_state, n_state;
    logic [THRESH_W-1:0] r_thresh;
    logic [CW-1:0]       r_count;
    logic                r_fresh;
    logic                r_full;
    logic [CH_W-1:0]     r_ch;
    logic [NUM_CH-1:0]   r_vld;
    t_sample             r_samp [NUM_CH];
    t_sample             r_avg [NUM_CH];
    t_sample             r_out_avg [NUM_CH];
    logic                r_out_fresh;
    logic                r_out_full;
    logic                r_out_valid;

    logic          w_acc;
    logic [CW-1:0] w_base;
    logic          w_full;
    logic [CW-1:0] w_newcnt;
    logic          w_fresh;
    logic          w_act;
    logic          w_last;
    t_sum          w_rdata;
    t_sum          w_old;
    logic signed [SUM_W:0] w_ext;
    t_sum          w_newsum;
    logic          w_ram_re;
    logic          w_ram_we;
    logic          w_div_start;
    logic          w_div_done;
    t_sample       w_div_q;
    logic          w_push;
    logic          w_ready;

    assign w_acc    = i_scan.valid && w_ready;
    assign w_base   = i_scan.restart ? '0 : r_count;
    assign w_full   = w_base >= CNT_MAX;
    assign w_newcnt = w_full ? w_base : w_base + 1'b1;
    assign w_fresh  = CMPW'(w_newcnt) > CMPW'(r_thresh);
    assign w_act    = r_ch < CH_ACT;
    assign w_last   = r_ch == CH_LAST;

    assign w_old = r_vld[r_ch] ? w_rdata : '0;
    assign w_ext = {w_old[SUM_W-1], w_old} + (SUM_W+1)'(r_samp[r_ch]);

    always_comb begin
        if (r_full) begin
            w_newsum = w_old;
        end else if (w_ext[SUM_W] != w_ext[SUM_W-1]) begin
            w_newsum = w_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_newsum = w_ext[SUM_W-1:0];
        end
    end

    mba_sum_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_ch),
        .i_wdata (w_newsum),
        .i_re    (w_ram_re),
        .i_raddr (r_ch),
        .o_rdata (w_rdata)
    );

    mba_div #(
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_newsum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                if (r_fresh && w_act) n_state = S_DIV;
                else if (w_last)      n_state = S_PUSH;
                else                  n_state = S_READ;
            end
            S_DIV: begin
                if (w_div_done) n_state = w_last ? S_PUSH : S_READ;
            end
            S_PUSH: begin
                if (w_push) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ready     = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_we    = 1'b0;
        w_div_start = 1'b0;
        w_push      = 1'b0;
        unique case (r_state)
            S_IDLE: w_ready = 1'b1;
            S_READ: w_ram_re = 1'b1;
            S_ADD: begin
                w_ram_we    = w_act && !r_full;
                w_div_start = w_act && r_fresh;
            end
            S_DIV: ;
            S_PUSH: w_push = !r_out_valid || o_avg.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thresh    <= THRESH_RESET;
            r_count     <= '0;
            r_ch        <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_avg[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (w_acc) begin
                r_count <= w_newcnt;
                r_ch    <= '0;
                if (i_scan.restart) begin
                    r_vld <= '0;
                end
            end
            if (w_ram_we) begin
                r_vld[r_ch] <= 1'b1;
            end
            if ((r_state == S_ADD && !(r_fresh && w_act)) ||
                (r_state == S_DIV && w_div_done)) begin
                if (!w_last) r_ch <= r_ch + 1'b1;
            end
            if (r_state == S_DIV && w_div_done) begin
                r_avg[r_ch] <= w_div_q;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_avg.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_fresh   <= w_fresh;
            r_full    <= w_full;
            r_samp[0] <= i_scan.x_rate;
            r_samp[1] <= i_scan.y_rate;
            r_samp[2] <= i_scan.z_rate;
            r_samp[3] <= i_scan.ref_volt;
            r_samp[4] <= i_scan.x_accel;
            r_samp[5] <= i_scan.y_accel;
            r_samp[6] <= i_scan.z_accel;
            r_samp[7] <= i_scan.aux_zero;
            r_samp[8] <= i_scan.aux_one;
        end
        if (w_push) begin
            r_out_avg   <= r_avg;
            r_out_fresh <= r_fresh;
            r_out_full  <= r_full;
        end
    end

    assign i_scan.ready       = w_ready;
    assign o_avg.valid        = r_out_valid;
    assign o_avg.x_rate_avg   = r_out_avg[0];
    assign o_avg.y_rate_avg   = r_out_avg[1];
    assign o_avg.z_rate_avg   = r_out_avg[2];
    assign o_avg.ref_volt_avg = r_out_avg[3];
    assign o_avg.x_accel_avg  = r_out_avg[4];
    assign o_avg.y_accel_avg  = r_out_avg[5];
    assign o_avg.z_accel_avg  = r_out_avg[6];
    assign o_avg.aux_zero_avg = r_out_avg[7];
    assign o_avg.aux_one_avg  = r_out_avg[8];
    assign o_avg.fresh        = r_out_fresh;
    assign o_avg.count_full   = r_out_full;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_scan.ready)
        else $error("scan transfer possible while busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("scan count beyond saturation");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_no_ram_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram_we && w_ram_re))
        else $error("sum RAM read and write in one cycle");

    a_unused_aux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AUX_CHANNELS < 2) |-> (r_avg[NUM_CH-1] == '0))
        else $error("inactive auxiliary average changed");

endmodule

[tb/mba_avg_checker.sv]
`timescale 1ns / 100ps

module mba_avg_checker import mba_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THRESH_W-1:0] i_cfg_wdata,
    mba_scan_if                 i_scan,
    mba_avg_if                  i_avg,
    output int                  o_pending,
    output int                  o_failures
);

    localparam int AUX_ACTIVE = AUX_CHANNELS_DEF;
    localparam int SCAN_LIMIT = COUNT_MAX_DEF;

    typedef struct {
        t_sample avg [NUM_CH];
        logic    fresh;
        logic    count_full;
    } t_avg_result;

    t_sum                ch_sum [NUM_CH];
    t_sample             ch_avg [NUM_CH];
    int                  scan_count;
    logic [THRESH_W-1:0] threshold;
    t_avg_result         avg_expect_q [$];
    int                  failures;
    string               ch_names [NUM_CH] = '{
        "x_rate_avg", "y_rate_avg", "z_rate_avg", "ref_volt_avg", "x_accel_avg",
        "y_accel_avg", "z_accel_avg", "aux_zero_avg", "aux_one_avg"
    };

    function automatic bit is_active(int ch);
        return ch < FIRST_AUX || (ch - FIRST_AUX) < AUX_ACTIVE;
    endfunction

    always @(posedge i_clk) begin : watch
        t_sample     smp [NUM_CH];
        t_sample     got [NUM_CH];
        t_avg_result nxt;
        t_avg_result want;
        longint      wide;

        if (!i_rst_n) begin
            foreach (ch_sum[i]) begin
                ch_sum[i] = '0;
                ch_avg[i] = '0;
            end
            scan_count = 0;
            threshold  = THRESH_RESET;
            avg_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                threshold = i_cfg_wdata;
            end

            if (i_scan.valid && i_scan.ready) begin
                smp = '{i_scan.x_rate, i_scan.y_rate, i_scan.z_rate, i_scan.ref_volt,
                        i_scan.x_accel, i_scan.y_accel, i_scan.z_accel,
                        i_scan.aux_zero, i_scan.aux_one};
                if (i_scan.restart) begin
                    foreach (ch_sum[i]) ch_sum[i] = '0;
                    scan_count = 0;
                end
                nxt.count_full = (scan_count >= SCAN_LIMIT);
                if (!nxt.count_full) begin
                    for (int i = 0; i < NUM_CH; i++) begin
                        if (is_active(i)) begin
                            wide = longint'(ch_sum[i]) + longint'(smp[i]);
                            if (wide > 64'sh7FFF_FFFF)  wide = 64'sh7FFF_FFFF;
                            if (wide < -64'sh8000_0000) wide = -64'sh8000_0000;
                            ch_sum[i] = t_sum'(wide);
                        end
                    end
                    scan_count++;
                end
                nxt.fresh = (scan_count > int'(threshold));
                if (nxt.fresh) begin
                    for (int i = 0; i < NUM_CH; i++) begin
                        if (is_active(i)) begin
                            // signed divide truncates toward zero
                            wide = longint'(ch_sum[i]) / longint'(scan_count);
                            if (wide > 32767)  wide = 32767;
                            if (wide < -32768) wide = -32768;
                            ch_avg[i] = t_sample'(wide);
                        end
                    end
                end
                nxt.avg = ch_avg;
                avg_expect_q.push_back(nxt);
            end

            if (i_avg.valid && i_avg.ready) begin
                got = '{i_avg.x_rate_avg, i_avg.y_rate_avg, i_avg.z_rate_avg,
                        i_avg.ref_volt_avg, i_avg.x_accel_avg, i_avg.y_accel_avg,
                        i_avg.z_accel_avg, i_avg.aux_zero_avg, i_avg.aux_one_avg};
                if (avg_expect_q.size() == 0) begin
                    $error("average transfer with no scan outstanding");
                    failures++;
                end else begin
                    want = avg_expect_q.pop_front();
                    for (int i = 0; i < NUM_CH; i++) begin
                        if (got[i] !== want.avg[i]) begin
                            $error("%s: expected %0d, got %0d", ch_names[i], want.avg[i],
                                   got[i]);
                            failures++;
                        end
                    end
                    if (i_avg.fresh !== want.fresh) begin
                        $error("fresh: expected %0d, got %0d", want.fresh, i_avg.fresh);
                        failures++;
                    end
                    if (i_avg.count_full !== want.count_full) begin
                        $error("count_full: expected %0d, got %0d", want.count_full,
                               i_avg.count_full);
                        failures++;
                    end
                end
            end
        end

        o_pending  <= avg_expect_q.size();
        o_failures <= failures;
    end

endmodule

[tb/tb_multichannel_boxcar_averager_top.sv]
`timescale 1ns / 100ps

module tb_multichannel_boxcar_averager_top;
    import mba_pkg::*;

    localparam int      RAND_PHASES   = 10;
    localparam int      PHASE_SCANS   = 115;
    localparam int      LONG_HOLD     = 3000;
    localparam int      HOLD_AT       = 400;
    localparam int      SETTLE_CYCLES = 400;
    localparam int      WATCHDOG_MAX  = 20000;
    localparam t_sample S_MAX         = 16'sh7FFF;
    localparam t_sample S_MIN         = 16'sh8000;

    typedef struct {
        logic    restart;
        t_sample ch [NUM_CH];
    } t_scan;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_we;
    logic [THRESH_W-1:0] cfg_wdata;
    int                  pending;
    int                  failures;
    int                  idle_cycles = 0;
    int                  burst_left  = 0;
    int                  pat_left    = 0;
    bit                  gaps_on     = 1'b1;
    logic [15:0]         stall_pat;
    t_sample             ch_bias [NUM_CH];

    mba_scan_if scan_if ();
    mba_avg_if  avg_if ();

    multichannel_boxcar_averager_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_scan      (scan_if),
        .o_avg       (avg_if)
    );

    mba_avg_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_scan      (scan_if),
        .i_avg       (avg_if),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((scan_if.valid && scan_if.ready) || (avg_if.valid && avg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side: stall pattern, plus one long hold-off after some transfers
    initial begin
        int taken;
        bit held;

        taken = 0;
        held  = 1'b0;
        avg_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (avg_if.valid && avg_if.ready) taken++;
            if (!held && taken >= HOLD_AT) begin
                held = 1'b1;
                avg_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (pat_left == 0) begin
                    stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                    pat_left  = $urandom_range(16, 200);
                end
                pat_left--;
                avg_if.ready <= stall_pat[pat_left % 16];
            end
        end
    end

    function automatic t_sample rand_sample(int ch);
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            4:       return t_sample'(int'($urandom_range(0, 64)) - 32);
            5, 6:    return t_sample'(int'(ch_bias[ch]) + int'($urandom_range(0, 400)) - 200);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_scan rand_scan(int restart_odds);
        t_scan s;
        s.restart = ($urandom_range(0, restart_odds) == 0);
        foreach (s.ch[i]) s.ch[i] = rand_sample(i);
        return s;
    endfunction

    function automatic t_scan flat_scan(logic restart, t_sample v);
        t_scan s;
        s.restart = restart;
        foreach (s.ch[i]) s.ch[i] = v;
        return s;
    endfunction

    task automatic send_scan(input t_scan s);
        if (burst_left == 0) begin
            if (gaps_on) begin
                scan_if.valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        scan_if.valid    <= 1'b1;
        scan_if.restart  <= s.restart;
        scan_if.x_rate   <= s.ch[0];
        scan_if.y_rate   <= s.ch[1];
        scan_if.z_rate   <= s.ch[2];
        scan_if.ref_volt <= s.ch[3];
        scan_if.x_accel  <= s.ch[4];
        scan_if.y_accel  <= s.ch[5];
        scan_if.z_accel  <= s.ch[6];
        scan_if.aux_zero <= s.ch[7];
        scan_if.aux_one  <= s.ch[8];
        do @(posedge i_clk); while (!scan_if.ready);
    endtask

    task automatic wait_drained();
        scan_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        t_scan               s;
        logic [THRESH_W-1:0] thr;
        int                  restart_odds;

        i_rst_n   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        scan_if.valid <= 1'b0;
        s = flat_scan(1'b0, '0);
        scan_if.restart  <= 1'b0;
        scan_if.x_rate   <= '0;
        scan_if.y_rate   <= '0;
        scan_if.z_rate   <= '0;
        scan_if.ref_volt <= '0;
        scan_if.x_accel  <= '0;
        scan_if.y_accel  <= '0;
        scan_if.z_accel  <= '0;
        scan_if.aux_zero <= '0;
        scan_if.aux_one  <= '0;
        foreach (ch_bias[i]) ch_bias[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset threshold: averages held at zero
        send_scan(flat_scan(1'b1, S_MAX));
        send_scan(flat_scan(1'b0, S_MIN));

        wait_drained();
        write_threshold('0);
        send_scan(flat_scan(1'b1, S_MAX));
        send_scan(flat_scan(1'b0, S_MAX));
        send_scan(flat_scan(1'b1, S_MIN));
        send_scan(flat_scan(1'b0, S_MIN));
        // negative odd sum truncates toward zero
        send_scan(flat_scan(1'b1, -16'sd3));
        send_scan(flat_scan(1'b0, '0));
        send_scan(flat_scan(1'b1, 16'sd3));
        send_scan(flat_scan(1'b0, '0));
        s.restart = 1'b1;
        foreach (s.ch[i]) s.ch[i] = (i % 2) ? S_MAX : S_MIN;
        send_scan(s);
        s.restart = 1'b0;
        foreach (s.ch[i]) s.ch[i] = (i % 2) ? S_MIN : S_MAX;
        send_scan(s);
        s.restart = 1'b1;
        foreach (s.ch[i]) s.ch[i] = t_sample'(i * 1000 - 4000);
        send_scan(s);

        // threshold equal to the first scan's count: averages held until the second scan
        wait_drained();
        write_threshold(12'd1);
        send_scan(flat_scan(1'b1, 16'sd1234));
        send_scan(flat_scan(1'b0, -16'sd77));

        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 4))
                0:       thr = '0;
                1, 2:    thr = THRESH_W'($urandom_range(1, 12));
                3:       thr = THRESH_W'($urandom_range(13, 60));
                default: thr = THRESH_W'($urandom_range(61, 300));
            endcase
            if (p == 0) thr = '0;
            restart_odds = $urandom_range(8, 60);
            gaps_on      = ($urandom_range(0, 3) != 0);
            foreach (ch_bias[i]) ch_bias[i] = t_sample'($urandom);
            wait_drained();
            write_threshold(thr);
            for (int n = 0; n < PHASE_SCANS; n++) begin
                send_scan(rand_scan(restart_odds));
            end
        end

        wait_drained();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
src/mba_pkg.sv
src/mba_ifs.sv
src/mba_sum_ram.sv
src/mba_div.sv
src/multichannel_boxcar_averager_top.sv
tb/mba_avg_checker.sv
tb/tb_multichannel_boxcar_averager_top.sv
